// File: design/fenwick_2d_prefix_max_top_assert.svh
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_max_top_assert
// Assertion macros shared by the checker of the prefix maximum tree.
// ----------------------------------------------------------------------------
`ifndef FENWICK_2D_PREFIX_MAX_TOP_ASSERT_SVH
`define FENWICK_2D_PREFIX_MAX_TOP_ASSERT_SVH

// Implication into the next cycle, switched off while reset is high.
`define F2DPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("f2dpm checker: property failed");

// Implication into the next cycle that also holds across reset.
`define F2DPM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("f2dpm checker: property failed");

`endif

// File: design/f2dpm_pkg.sv
// ----------------------------------------------------------------------------
// f2dpm_pkg
// Types and constants shared by the two-dimensional prefix maximum tree.
// ----------------------------------------------------------------------------
package f2dpm_pkg;

   localparam int COORD_W     = 7;
   localparam int WALK_W      = COORD_W + 1;
   localparam int SIZE_W      = 7;
   localparam int IN_VALUE_W  = 32;
   localparam int OUT_W       = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROWS = 1'b0,
      REG_COLS = 1'b1
   } f2dpm_reg_type;

   typedef enum logic {
      FUNC_RAISE = 1'b0,
      FUNC_QUERY = 1'b1
   } f2dpm_func_type;

   typedef struct packed {
      logic               is_query;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } f2dpm_cmd_type;

   typedef struct packed {
      logic              clear_req;
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
   } f2dpm_ctl_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_WALK,
      BACK_DRAIN
   } f2dpm_back_state_type;

endpackage

// File: design/f2dpm_front.sv
// ----------------------------------------------------------------------------
// f2dpm_front
// Holds the size registers, accepts transactions and classifies them.
// ----------------------------------------------------------------------------
module f2dpm_front
   import f2dpm_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic [COORD_W-1:0]     req_row,
   input  logic [COORD_W-1:0]     req_col,
   input  logic [IN_VALUE_W-1:0]  req_value,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata,
   input  logic                   back_clearing,
   input  logic                   queue_full,
   output logic                   push,
   output f2dpm_cmd_type          push_cmd,
   output logic [VALUE_WIDTH-1:0] push_value,
   output f2dpm_ctl_type          ctl
);

   localparam int ROW_LIMIT = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam int COL_LIMIT = (MAX_COLS > 127) ? 127 : MAX_COLS;

   logic [SIZE_W-1:0]                rows_ff;
   logic [SIZE_W-1:0]                cols_ff;
   logic [SIZE_W-1:0]                eff_rows;
   logic [SIZE_W-1:0]                eff_cols;
   logic [VALUE_WIDTH+IN_VALUE_W-1:0] value_ext;
   logic                             accept;
   logic                             is_query;
   logic                             update_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROWS: rows_ff <= csr_wdata;
            REG_COLS: cols_ff <= csr_wdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      eff_rows  = (rows_ff > SIZE_W'(ROW_LIMIT)) ? SIZE_W'(ROW_LIMIT) : rows_ff;
      eff_cols  = (cols_ff > SIZE_W'(COL_LIMIT)) ? SIZE_W'(COL_LIMIT) : cols_ff;
      busy      = back_clearing || queue_full;
      accept    = start && !busy;
      is_query  = (req_func == FUNC_QUERY);
      update_ok = (req_row != '0) && (req_col != '0) &&
                  (req_row <= eff_rows) && (req_col <= eff_cols);
      push      = accept && (is_query || update_ok);

      push_cmd.is_query = is_query;
      if (is_query) begin
         push_cmd.row = (req_row > eff_rows) ? eff_rows : req_row;
         push_cmd.col = (req_col > eff_cols) ? eff_cols : req_col;
      end else begin
         push_cmd.row = req_row;
         push_cmd.col = req_col;
      end

      value_ext  = {{VALUE_WIDTH{1'b0}}, req_value};
      push_value = value_ext[VALUE_WIDTH-1:0];

      ctl.clear_req = csr_we && ((csr_index == REG_ROWS) || (csr_index == REG_COLS));
      ctl.rows      = eff_rows;
      ctl.cols      = eff_cols;
   end

endmodule

// File: design/f2dpm_queue.sv
// ----------------------------------------------------------------------------
// f2dpm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module f2dpm_queue
   import f2dpm_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  f2dpm_cmd_type          push_cmd,
   input  logic [VALUE_WIDTH-1:0] push_value,
   input  logic                   pop,
   output f2dpm_cmd_type          head_cmd,
   output logic [VALUE_WIDTH-1:0] head_value,
   output logic                   empty,
   output logic                   full
);

   f2dpm_cmd_type          cmd_ff [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0] val_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff;
   logic [QPTR_W-1:0]      wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff;
   logic [QPTR_W-1:0]      rd_ptr_in;
   logic [QPTR_W:0]        count_ff;
   logic [QPTR_W:0]        count_in;

   always_comb begin
      empty      = (count_ff == '0);
      full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head_cmd   = cmd_ff[rd_ptr_ff];
      head_value = val_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= push_cmd;
         val_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

// File: design/f2dpm_back.sv
// ----------------------------------------------------------------------------
// f2dpm_back
// Node store, clearing pass and the walker that raises or reads the nodes.
// ----------------------------------------------------------------------------
module f2dpm_back
   import f2dpm_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  f2dpm_ctl_type          ctl,
   input  logic                   queue_empty,
   input  f2dpm_cmd_type          head_cmd,
   input  logic [VALUE_WIDTH-1:0] head_value,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   output logic [OUT_W-1:0]       rsp_prefix_max
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   f2dpm_back_state_type   state_ff;
   f2dpm_back_state_type   state_in;
   logic [AW-1:0]          clr_addr_ff;
   logic [AW-1:0]          clr_addr_in;
   logic [WALK_W-1:0]      i_ff;
   logic [WALK_W-1:0]      i_in;
   logic [WALK_W-1:0]      j_ff;
   logic [WALK_W-1:0]      j_in;
   logic [WALK_W-1:0]      c_ff;
   logic [WALK_W-1:0]      c_in;
   logic                   query_ff;
   logic                   query_in;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [VALUE_WIDTH-1:0] val_in;
   logic [VALUE_WIDTH-1:0] best_ff;
   logic [VALUE_WIDTH-1:0] best_in;
   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   logic [AW-1:0]          s2_addr_ff;
   logic [AW-1:0]          s2_addr_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [OUT_W-1:0]       rsp_data_ff;
   logic [OUT_W-1:0]       rsp_data_in;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   logic [WALK_W-1:0]          lsb_i;
   logic [WALK_W-1:0]          lsb_j;
   logic [WALK_W-1:0]          i_next;
   logic [WALK_W-1:0]          j_next;
   logic [WALK_W-1:0]          rows_ext;
   logic [WALK_W-1:0]          cols_ext;
   logic [RW+WALK_W-1:0]       row_wide;
   logic [CW+WALK_W-1:0]       col_wide;
   logic [AW-1:0]              node_addr;
   logic                       walk_done;
   logic [VALUE_WIDTH-1:0]     best_now;
   logic [VALUE_WIDTH+OUT_W-1:0] best_ext;

   always_comb begin
      rows_ext  = {1'b0, ctl.rows};
      cols_ext  = {1'b0, ctl.cols};
      lsb_i     = i_ff & (~i_ff + 1'b1);
      lsb_j     = j_ff & (~j_ff + 1'b1);
      row_wide  = {{RW{1'b0}}, i_ff - 1'b1};
      col_wide  = {{CW{1'b0}}, j_ff - 1'b1};
      node_addr = {row_wide[RW-1:0], col_wide[CW-1:0]};

      i_next    = i_ff;
      walk_done = 1'b0;
      if (query_ff) begin
         j_next = j_ff - lsb_j;
         if (j_next == '0) begin
            j_next    = c_ff;
            i_next    = i_ff - lsb_i;
            walk_done = (i_next == '0);
         end
      end else begin
         j_next = j_ff + lsb_j;
         if (j_next > cols_ext) begin
            j_next    = c_ff;
            i_next    = i_ff + lsb_i;
            walk_done = (i_next > rows_ext);
         end
      end

      best_now = (s2_valid_ff && (rd_data_ff > best_ff)) ? rd_data_ff : best_ff;
      best_ext = {{OUT_W{1'b0}}, best_now};
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      c_in         = c_ff;
      query_in     = query_ff;
      val_in       = val_ff;
      best_in      = best_now;
      s2_valid_in  = 1'b0;
      s2_addr_in   = node_addr;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = node_addr;
      wr_en        = s2_valid_ff && !query_ff && (rd_data_ff < val_ff);
      wr_addr      = s2_addr_ff;
      wr_data      = val_ff;

      case (state_ff)
         BACK_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               i_in     = {1'b0, head_cmd.row};
               j_in     = {1'b0, head_cmd.col};
               c_in     = {1'b0, head_cmd.col};
               query_in = head_cmd.is_query;
               val_in   = head_value;
               best_in  = '0;
               if ((head_cmd.row == '0) || (head_cmd.col == '0)) begin
                  state_in = BACK_DRAIN;
               end else begin
                  state_in = BACK_WALK;
               end
            end
         end
         BACK_WALK: begin
            rd_en       = 1'b1;
            s2_valid_in = 1'b1;
            i_in        = i_next;
            j_in        = j_next;
            if (walk_done) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            rsp_valid_in = query_ff;
            rsp_data_in  = best_ext[OUT_W-1:0];
            state_in     = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (ctl.clear_req) begin
         state_in    = BACK_CLEAR;
         clr_addr_in = '0;
      end

      clearing       = (state_ff == BACK_CLEAR);
      rsp_valid      = rsp_valid_ff;
      rsp_prefix_max = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clr_addr_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      c_ff        <= c_in;
      query_ff    <= query_in;
      val_ff      <= val_in;
      best_ff     <= best_in;
      s2_addr_ff  <= s2_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: design/fenwick_2d_prefix_max_top.sv
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_max_top
// Two-dimensional binary indexed tree of prefix maxima over unsigned values.
//
//   Channel   Ports                                   Handshake
//   request   start, busy, req_func/row/col/value     start high, busy low
//   result    rsp_valid, rsp_prefix_max               one-cycle strobe
//   config    csr_we, csr_index, csr_wdata            write enable
//
// In the back part, a transaction walks N nodes, where N is the number of
// nodes on the row chain times the column chain; the single memory port pair
// visits one node per cycle (49 nodes at most at 64 by 64).
// Reset and every size write start a clearing pass that writes zero to all
// 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) nodes (4096 by default).
// busy is high during the clearing pass and while the two-entry queue is full.
// A query result goes from rd_data_ff through BACK_DRAIN to registered outputs.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_max_top
   import f2dpm_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic [COORD_W-1:0]     req_row,
   input  logic [COORD_W-1:0]     req_col,
   input  logic [IN_VALUE_W-1:0]  req_value,
   output logic                   rsp_valid,
   output logic [OUT_W-1:0]       rsp_prefix_max,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   logic                   push;
   f2dpm_cmd_type          push_cmd;
   logic [VALUE_WIDTH-1:0] push_value;
   f2dpm_ctl_type          ctl;
   logic                   pop;
   f2dpm_cmd_type          head_cmd;
   logic [VALUE_WIDTH-1:0] head_value;
   logic                   queue_empty;
   logic                   queue_full;
   logic                   back_clearing;

   f2dpm_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .back_clearing (back_clearing),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd),
      .push_value    (push_value),
      .ctl           (ctl)
   );

   f2dpm_queue #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_value (push_value),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_value (head_value),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   f2dpm_back #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .queue_empty    (queue_empty),
      .head_cmd       (head_cmd),
      .head_value     (head_value),
      .pop            (pop),
      .clearing       (back_clearing),
      .rsp_valid      (rsp_valid),
      .rsp_prefix_max (rsp_prefix_max)
   );

endmodule

// File: design/f2dpm_checker.sv
// ----------------------------------------------------------------------------
// f2dpm_checker
// Port-level checks of the prefix maximum tree, bound to the top level.
// ----------------------------------------------------------------------------
`include "fenwick_2d_prefix_max_top_assert.svh"

module f2dpm_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic csr_we
);

   `F2DPM_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, busy)
   `F2DPM_ASSERT_NEXT(a_size_write_clears, clock, reset, csr_we, busy)
   `F2DPM_ASSERT_NEXT(a_result_spacing, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind fenwick_2d_prefix_max_top f2dpm_checker u_f2dpm_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_we    (csr_we)
);

// File: dv/fenwick_2d_prefix_max_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_max_top_test
// Self-checking testbench of the two-dimensional prefix maximum tree. A
// clocked driver feeds raise and query transactions from a queue with random
// gaps. A clocked monitor compares every result strobe with the answer of a
// behavioural copy of the tree. The run steps through several table sizes,
// the smallest, the largest, zero and oversized among them.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_max_top_test;
   import f2dpm_pkg::*;

   localparam int          TREE_ROWS      = 64;
   localparam int          TREE_COLS      = 64;
   localparam int          COORD_MAX      = 64;
   localparam int          HALF_PERIOD    = 4;
   localparam int          RESET_CYCLES   = 7;
   localparam int          SETTLE_CYCLES  = 200;
   localparam int          TAIL_CYCLES    = 200;
   localparam int          REPORT_LIMIT   = 10;
   localparam longint      TIMEOUT_CYCLES = 800000;

   typedef struct {
      f2dpm_func_type        func;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic [IN_VALUE_W-1:0] value;
   } tree_op_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   logic                   req_func  = 1'b0;
   logic [COORD_W-1:0]     req_row   = '0;
   logic [COORD_W-1:0]     req_col   = '0;
   logic [IN_VALUE_W-1:0]  req_value = '0;
   logic                   rsp_valid;
   logic [OUT_W-1:0]       rsp_prefix_max;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]      csr_wdata = '0;

   fenwick_2d_prefix_max_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_prefix_max (rsp_prefix_max),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   tree_op_type       pending_ops[$];
   logic [OUT_W-1:0]  expected_max_q[$];
   logic [OUT_W-1:0]  node_max [TREE_ROWS][TREE_COLS];
   logic [SIZE_W-1:0] rows_reg = SIZE_RESET;
   logic [SIZE_W-1:0] cols_reg = SIZE_RESET;
   tree_op_type       queued_op;
   logic [OUT_W-1:0]  wanted_max;
   int unsigned       idle_left    = 0;
   int unsigned       calm_left    = 0;
   int unsigned       fail_count   = 0;
   int unsigned       raises_done  = 0;
   int unsigned       queries_done = 0;
   int unsigned       results_seen = 0;
   int unsigned       size_writes  = 0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] reg_value, int unsigned limit);
      return (reg_value > limit) ? limit : reg_value;
   endfunction

   function automatic void clear_tree();
      foreach (node_max[i, j]) node_max[i][j] = '0;
   endfunction

   function automatic void raise_point(int unsigned r, int unsigned c, logic [OUT_W-1:0] v);
      int unsigned nr;
      int unsigned nc;
      nr = clamp_size(rows_reg, TREE_ROWS);
      nc = clamp_size(cols_reg, TREE_COLS);
      if (r == 0 || c == 0 || r > nr || c > nc) return;
      for (int unsigned i = r; i <= nr; i += i & (~i + 1)) begin
         for (int unsigned j = c; j <= nc; j += j & (~j + 1)) begin
            if (node_max[i-1][j-1] < v) node_max[i-1][j-1] = v;
         end
      end
   endfunction

   function automatic logic [OUT_W-1:0] prefix_max_of(int unsigned r, int unsigned c);
      int unsigned      nr;
      int unsigned      nc;
      logic [OUT_W-1:0] best;
      nr   = clamp_size(rows_reg, TREE_ROWS);
      nc   = clamp_size(cols_reg, TREE_COLS);
      best = '0;
      if (r > nr) r = nr;
      if (c > nc) c = nc;
      for (int unsigned i = r; i > 0; i -= i & (~i + 1)) begin
         for (int unsigned j = c; j > 0; j -= j & (~j + 1)) begin
            if (node_max[i-1][j-1] > best) best = node_max[i-1][j-1];
         end
      end
      return best;
   endfunction

   function automatic void apply_op(f2dpm_func_type func, logic [COORD_W-1:0] row,
                                    logic [COORD_W-1:0] col, logic [IN_VALUE_W-1:0] value);
      if (func == FUNC_QUERY) begin
         expected_max_q.push_back(prefix_max_of(row, col));
         queries_done++;
      end else begin
         raise_point(row, col, value);
         raises_done++;
      end
   endfunction

   function automatic void add_op(f2dpm_func_type func, logic [COORD_W-1:0] row,
                                  logic [COORD_W-1:0] col, logic [IN_VALUE_W-1:0] value);
      tree_op_type op;
      op.func  = func;
      op.row   = row;
      op.col   = col;
      op.value = value;
      pending_ops.push_back(op);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(int unsigned limit);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1 || limit == 0) return COORD_W'($urandom_range(0, COORD_MAX));
      return COORD_W'($urandom_range(1, limit));
   endfunction

   function automatic logic [IN_VALUE_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return '0;
         1: return '1;
         2, 3, 4: return $urandom_range(0, 255);
         default: return $urandom();
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if (sel < 3) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic void add_random_ops(int unsigned count);
      int unsigned nr;
      int unsigned nc;
      nr = clamp_size(rows_reg, TREE_ROWS);
      nc = clamp_size(cols_reg, TREE_COLS);
      repeat (count) begin
         add_op(($urandom_range(0, 1) == 1) ? FUNC_QUERY : FUNC_RAISE,
                pick_coord(nr), pick_coord(nc), pick_value());
      end
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (pending_ops.size() != 0 || start || expected_max_q.size() != 0) @(negedge clock);
   endtask

   task automatic wait_clear_pass();
      @(negedge clock);
      while (!busy) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_size(f2dpm_reg_type index, logic [SIZE_W-1:0] size);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == REG_ROWS) rows_reg = size;
      else cols_reg = size;
      clear_tree();
      size_writes++;
      wait_clear_pass();
   endtask

   // A transaction is taken at an edge where start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            apply_op(f2dpm_func_type'(req_func), req_row, req_col, req_value);
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (pending_ops.size() != 0) begin
            queued_op = pending_ops.pop_front();
            req_func  <= queued_op.func;
            req_row   <= queued_op.row;
            req_col   <= queued_op.col;
            req_value <= queued_op.value;
            start     <= 1'b1;
            idle_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_max_q.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("ERROR: result with no query outstanding, got %h", rsp_prefix_max);
            end
            fail_count++;
         end else begin
            wanted_max = expected_max_q.pop_front();
            results_seen++;
            if (rsp_prefix_max !== wanted_max) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("ERROR: prefix_max of result %0d: expected %h, got %h",
                           results_seen, wanted_max, rsp_prefix_max);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin
      clear_tree();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_clear_pass();

      // Full size: empty tree, zero coordinates, extreme values and corners.
      add_op(FUNC_QUERY, 64, 64, 32'h1234_5678);
      add_op(FUNC_RAISE, 64, 64, 32'd5);
      add_op(FUNC_QUERY, 64, 64, 32'd0);
      add_op(FUNC_QUERY, 63, 64, 32'd0);
      add_op(FUNC_RAISE, 1, 1, 32'd0);
      add_op(FUNC_RAISE, 0, 5, 32'd100);
      add_op(FUNC_RAISE, 5, 0, 32'd100);
      add_op(FUNC_QUERY, 0, 64, 32'd0);
      add_op(FUNC_QUERY, 64, 0, 32'd0);
      add_op(FUNC_RAISE, 32, 17, 32'h8000_0000);
      add_op(FUNC_QUERY, 32, 17, 32'd0);
      add_op(FUNC_QUERY, 31, 64, 32'd0);
      add_op(FUNC_RAISE, 1, 1, 32'hFFFF_FFFF);
      add_op(FUNC_QUERY, 1, 1, 32'd0);
      add_op(FUNC_QUERY, 64, 64, 32'd0);

      // Small table: updates outside it are dropped and queries are clamped.
      write_size(REG_ROWS, 7'd5);
      write_size(REG_COLS, 7'd7);
      add_op(FUNC_RAISE, 6, 3, 32'd1000);
      add_op(FUNC_RAISE, 3, 8, 32'd1000);
      add_op(FUNC_RAISE, 5, 7, 32'd42);
      add_op(FUNC_QUERY, 64, 64, 32'd0);
      add_op(FUNC_QUERY, 6, 3, 32'd0);
      add_op(FUNC_QUERY, 5, 7, 32'd0);
      add_random_ops(80);

      // Rewriting the same size must still clear the table.
      write_size(REG_ROWS, 7'd5);
      add_op(FUNC_QUERY, 5, 7, 32'd0);
      add_random_ops(40);

      write_size(REG_ROWS, 7'd0);
      add_op(FUNC_RAISE, 1, 1, 32'd9);
      add_op(FUNC_QUERY, 64, 64, 32'd0);
      add_random_ops(20);

      // Oversized registers saturate to the full table.
      write_size(REG_ROWS, 7'd127);
      write_size(REG_COLS, 7'd100);
      add_random_ops(100);
      wait_drained();
      add_random_ops(100);

      write_size(REG_ROWS, 7'd1);
      write_size(REG_COLS, 7'd64);
      add_random_ops(60);

      write_size(REG_ROWS, 7'd64);
      write_size(REG_COLS, 7'd1);
      add_random_ops(60);

      write_size(REG_COLS, 7'd64);
      add_random_ops(140);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Summary: %0d raise and %0d query transactions over %0d size writes.",
               raises_done, queries_done, size_writes);
      $display("Summary: %0d results compared, %0d failures.", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("Timeout: the run did not complete in time.");
      $display("FAILED: results differ");
      $finish;
   end

endmodule
